// ===== sv/shfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// shfcd_pkg
// Shared constants and helpers of the header-sync frame checksum deframer.
// ----------------------------------------------------------------------------
package shfcd_pkg;

	// Frame geometry: two header bytes, payload, one checksum byte.
	localparam int FRAME_LEN   = 32;
	localparam int PAYLOAD_LEN = FRAME_LEN - 3;

	localparam int BYTE_W = 8;
	localparam int IDX_W  = 5;
	localparam int PTR_W  = $clog2(FRAME_LEN);
	localparam int FILL_W = $clog2(FRAME_LEN + 1);
	localparam int EMIT_W = $clog2(PAYLOAD_LEN + 1);

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h5A;

	// Ring pointer advance, modulo FRAME_LEN. n stays below FRAME_LEN.
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
		input logic [PTR_W-1:0] n);
		logic [PTR_W:0] s;
		s = {1'b0, p} + {1'b0, n};
		if (s >= (PTR_W+1)'(FRAME_LEN)) begin
			s = s - (PTR_W+1)'(FRAME_LEN);
		end
		return s[PTR_W-1:0];
	endfunction

endpackage

// ===== sv/shfcd_in_if.sv =====
// ----------------------------------------------------------------------------
// shfcd_in_if
// Receive channel: one received byte or one idle event per word.
// ----------------------------------------------------------------------------
interface shfcd_in_if;
	logic                             valid;
	logic                             ready;
	logic [shfcd_pkg::BYTE_W-1:0]     rx_byte;
	logic                             idle_gap;

	modport source (output valid, output rx_byte, output idle_gap, input ready);
	modport sink   (input valid, input rx_byte, input idle_gap, output ready);
endinterface

// ===== sv/shfcd_out_if.sv =====
// ----------------------------------------------------------------------------
// shfcd_out_if
// Payload channel: one payload byte of an accepted frame per word.
// ----------------------------------------------------------------------------
interface shfcd_out_if;
	logic                             valid;
	logic                             ready;
	logic [shfcd_pkg::BYTE_W-1:0]     payload_byte;
	logic [shfcd_pkg::IDX_W-1:0]      payload_index;
	logic                             last_of_frame;

	modport source (output valid, output payload_byte, output payload_index,
		output last_of_frame, input ready);
	modport sink   (input valid, input payload_byte, input payload_index,
		input last_of_frame, output ready);
endinterface

// ===== sv/shfcd_ram.sv =====
// ----------------------------------------------------------------------------
// shfcd_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module shfcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/sync_header_frame_checksum_deframer_core.sv =====
// ----------------------------------------------------------------------------
// sync_header_frame_checksum_deframer_core
// Finds header-synced, checksum-protected frames in a byte stream and emits
// the payload of the first good frame of each burst.
// ----------------------------------------------------------------------------
// Usage:
//   din   : one word per received byte (idle_gap = 0) or per idle event
//           (idle_gap = 1, rx_byte ignored). An idle event ends the burst.
//   dout  : payload bytes of a found frame, payload_index 0..28, with
//           last_of_frame on the final one.
//   cfg_* : header_byte write, only while the block is idle.
// Throughput: one din word per cycle. A frame is checked in the cycle its
//   last byte is accepted; din.ready then drops while the payload is read
//   out of the window RAM (one read port, one byte a cycle while the output queue has room).
// Readout: after the closing byte is accepted, the first payload byte passes
//   busy_q, the RAM read stage and the output queue to dout, then one byte per cycle while dout.ready is high.
// Reset: window empty, checksum 0, header 0x5A; no clearing pass, the window
//   RAM is never read before it is written.
// Receiver stall: a two-entry output queue absorbs the RAM read latency;
//   payload reads pause while it is full, din stays stalled until all payload
//   reads are issued. Nothing is dropped.
// ----------------------------------------------------------------------------
module sync_header_frame_checksum_deframer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [shfcd_pkg::BYTE_W-1:0] cfg_wdata,
	shfcd_in_if.sink                     din,
	shfcd_out_if.source                  dout
);

	typedef struct packed {
		logic [shfcd_pkg::BYTE_W-1:0] data;
		logic [shfcd_pkg::IDX_W-1:0]  idx;
		logic                         last;
	} pl_ent_t;

	// Configuration
	logic [shfcd_pkg::BYTE_W-1:0] hdr_q;

	// Window control: the bytes live in a ring RAM; the first three window
	// bytes and the newest byte are mirrored in registers.
	logic [shfcd_pkg::FILL_W-1:0] fill_q;
	logic [shfcd_pkg::PTR_W-1:0]  ptr_q;     // next write slot, oldest once full
	logic [shfcd_pkg::BYTE_W-1:0] sum_q;     // sum of window bytes 0..FRAME_LEN-2
	logic                         taken_q;
	logic [shfcd_pkg::BYTE_W-1:0] w0_q, w1_q, w2_q, last_q;
	logic                         pend_s1;   // RAM data this cycle refills w2

	// Payload readout
	logic                         busy_q;
	logic [shfcd_pkg::EMIT_W-1:0] cnt_q;
	logic [shfcd_pkg::PTR_W-1:0]  base_q;
	logic                         infl_s1;
	logic [shfcd_pkg::IDX_W-1:0]  idx_s1;
	logic                         last_s1;

	// Output queue
	pl_ent_t                      ent_q [2];
	logic [1:0]                   fcnt_q;

	// RAM
	logic [shfcd_pkg::PTR_W-1:0]  raddr;
	logic [shfcd_pkg::BYTE_W-1:0] rdata;

	// Datapath
	logic                         acc, is_byte, full, found, issue, push, pop, room;
	logic [shfcd_pkg::BYTE_W-1:0] b, w0_n, w1_n, w2_eff, sum_n;
	logic [shfcd_pkg::FILL_W-1:0] fill_n;
	logic [shfcd_pkg::PTR_W-1:0]  ptr_n;
	logic [1:0]                   occ;
	pl_ent_t                      new_ent;

	assign din.ready = !busy_q;
	assign acc       = din.valid && din.ready;
	assign is_byte   = acc && !din.idle_gap;
	assign b         = din.rx_byte;
	assign full      = fill_q == shfcd_pkg::FILL_W'(shfcd_pkg::FRAME_LEN);

	// w2 is refilled from the RAM in the cycle after a shift; forward it.
	assign w2_eff = pend_s1 ? rdata : w2_q;

	always_comb begin
		if (full) begin
			w0_n   = w1_q;
			w1_n   = w2_eff;
			sum_n  = sum_q - w0_q + last_q;   // old byte 0 leaves, old last joins
			fill_n = fill_q;
		end else begin
			w0_n   = (fill_q == '0) ? b : w0_q;
			w1_n   = (fill_q == shfcd_pkg::FILL_W'(1)) ? b : w1_q;
			sum_n  = (fill_q < shfcd_pkg::FILL_W'(shfcd_pkg::FRAME_LEN - 1)) ?
				sum_q + b : sum_q;
			fill_n = fill_q + shfcd_pkg::FILL_W'(1);
		end
	end

	assign ptr_n = shfcd_pkg::ptr_add(ptr_q, shfcd_pkg::PTR_W'(1));

	assign found = is_byte && !taken_q
		&& (fill_n == shfcd_pkg::FILL_W'(shfcd_pkg::FRAME_LEN))
		&& (w0_n == hdr_q) && (w1_n == hdr_q) && (sum_n == b);

	// Queue occupancy counts the word still in the RAM read stage.
	assign pop   = dout.valid && dout.ready;
	assign push  = infl_s1;
	assign occ   = fcnt_q + {1'b0, infl_s1};
	assign room  = (occ - {1'b0, pop}) < 2'd2;
	assign issue = busy_q && room;

	// Read port: payload readout while busy, else prefetch of window byte 3.
	assign raddr = busy_q ?
		shfcd_pkg::ptr_add(base_q, shfcd_pkg::PTR_W'(cnt_q)) :
		shfcd_pkg::ptr_add(ptr_q, shfcd_pkg::PTR_W'(3));

	shfcd_ram #(
		.WIDTH (shfcd_pkg::BYTE_W),
		.DEPTH (shfcd_pkg::FRAME_LEN)
	) u_win_ram (
		.clk   (clk),
		.we    (is_byte),
		.waddr (ptr_q),
		.wdata (b),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign new_ent = '{data: rdata, idx: idx_s1, last: last_s1};

	assign dout.valid         = fcnt_q != 2'd0;
	assign dout.payload_byte  = ent_q[0].data;
	assign dout.payload_index = ent_q[0].idx;
	assign dout.last_of_frame = ent_q[0].last;

	// Config and window control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q   <= shfcd_pkg::HEADER_RESET;
			fill_q  <= '0;
			ptr_q   <= '0;
			sum_q   <= '0;
			taken_q <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				hdr_q <= cfg_wdata;
			end
			pend_s1 <= is_byte && full;
			if (acc && din.idle_gap) begin
				fill_q  <= '0;
				ptr_q   <= '0;
				sum_q   <= '0;
				taken_q <= 1'b0;
			end else if (is_byte) begin
				fill_q <= fill_n;
				ptr_q  <= ptr_n;
				sum_q  <= sum_n;
				if (found) begin
					taken_q <= 1'b1;
				end
			end
		end
	end

	// Window byte mirrors
	always_ff @(posedge clk) begin
		if (pend_s1) begin
			w2_q <= rdata;
		end
		if (is_byte) begin
			w0_q   <= w0_n;
			w1_q   <= w1_n;
			last_q <= b;
			if (fill_q == shfcd_pkg::FILL_W'(2)) begin
				w2_q <= b;
			end
		end
	end

	// Payload readout sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			infl_s1 <= 1'b0;
		end else begin
			infl_s1 <= issue;
			if (found) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + shfcd_pkg::EMIT_W'(1);
				if (cnt_q == shfcd_pkg::EMIT_W'(shfcd_pkg::PAYLOAD_LEN - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (found) begin
			// Payload starts two bytes past the oldest byte of the new window.
			base_q <= shfcd_pkg::ptr_add(ptr_n, shfcd_pkg::PTR_W'(2));
		end
		if (issue) begin
			idx_s1  <= shfcd_pkg::IDX_W'(cnt_q);
			last_s1 <= cnt_q == shfcd_pkg::EMIT_W'(shfcd_pkg::PAYLOAD_LEN - 1);
		end
	end

	// Output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   fcnt_q <= fcnt_q + 2'd1;
				2'b01:   fcnt_q <= fcnt_q - 2'd1;
				default: fcnt_q <= fcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b11: begin
				if (fcnt_q == 2'd1) begin
					ent_q[0] <= new_ent;
				end else begin
					ent_q[0] <= ent_q[1];
					ent_q[1] <= new_ent;
				end
			end
			2'b10: begin
				if (fcnt_q == 2'd0) begin
					ent_q[0] <= new_ent;
				end else begin
					ent_q[1] <= new_ent;
				end
			end
			2'b01: begin
				ent_q[0] <= ent_q[1];
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// Queue never overflows: a word landing on a full queue must meet a pop.
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		(infl_s1 && fcnt_q == 2'd2) |-> pop)
		else $error("output queue overflow");

	// The read port serves only one consumer per cycle.
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !infl_s1)
		else $error("window prefetch and payload read collide");

	// A found frame leaves a full window and marks the burst as taken.
	a_found_state: assert property (@(posedge clk) disable iff (!arst_n)
		found |=> (busy_q && taken_q
			&& fill_q == shfcd_pkg::FILL_W'(shfcd_pkg::FRAME_LEN)))
		else $error("frame found without full window state");

	// Last flag only on the final payload position.
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.last_of_frame)
			|-> dout.payload_index == shfcd_pkg::IDX_W'(shfcd_pkg::PAYLOAD_LEN - 1))
		else $error("last_of_frame on wrong payload index");
`endif

endmodule
